@@ design/cbs_pkg.sv @@
// shared types and constants of the cubic bezier sampler
package cbs_pkg;

    localparam int COORD_W  = 16;
    localparam int IDX_W    = 6;
    localparam int NUM_CTRL = 4;
    localparam int NUM_AXES = 3;
    localparam int QUOT_W   = 16;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        vec3_t a;
        vec3_t b;
        vec3_t c;
        vec3_t d;
    } ctrl_pts_t;

    // one queued segment: control points and the index of its final sample
    typedef struct packed {
        ctrl_pts_t        pts;
        logic [IDX_W-1:0] last_k;
    } seg_t;

    // one sample handed from the sequencer to the evaluation pipeline
    typedef struct packed {
        logic             valid;
        ctrl_pts_t        pts;
        logic [IDX_W-1:0] k;
        logic             last;
    } sample_req_t;

endpackage

@@ design/cubic_bezier_sampler_top.sv @@
// top level of the cubic bezier sampler
// Each accepted segment (four Q12.4 control points) produces SAMPLES curve points at
// t = k/SAMPLES, plus the endpoint at t = 1 when include_end is set, one point per
// clock while out_ready is high, so the single evaluation pipeline sets the sustained
// rate. Points are rounded to nearest, ties upward, and the final point of each run
// carries last_point. With the block empty and out_ready high, the first point of a
// segment passes through the input register, the two-entry segment queue, then
// squares, weights, products, dividend and a two-stage reciprocal multiply before it
// transfers. Besides the segment being sampled, up to two more can wait (one in the
// queue, one in the input register), and a stalled output holds the whole pipeline.
// include_end is to be written only while the block is idle.
module cubic_bezier_sampler_top #(
    parameter int SAMPLES = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cbs_pkg::coord_t           a_x,
    input  cbs_pkg::coord_t           a_y,
    input  cbs_pkg::coord_t           a_z,
    input  cbs_pkg::coord_t           b_x,
    input  cbs_pkg::coord_t           b_y,
    input  cbs_pkg::coord_t           b_z,
    input  cbs_pkg::coord_t           c_x,
    input  cbs_pkg::coord_t           c_y,
    input  cbs_pkg::coord_t           c_z,
    input  cbs_pkg::coord_t           d_x,
    input  cbs_pkg::coord_t           d_y,
    input  cbs_pkg::coord_t           d_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cbs_pkg::coord_t           point_x,
    output cbs_pkg::coord_t           point_y,
    output cbs_pkg::coord_t           point_z,
    output logic [cbs_pkg::IDX_W-1:0] sample_number,
    output logic                      last_point
);
    import cbs_pkg::*;

    ctrl_pts_t   in_pts;
    seg_t        front_seg;
    logic        front_valid;
    logic        queue_ready;
    seg_t        head;
    logic        head_valid;
    logic        pop;
    logic        adv;
    sample_req_t req;

    assign in_pts.a = '{x: a_x, y: a_y, z: a_z};
    assign in_pts.b = '{x: b_x, y: b_y, z: b_z};
    assign in_pts.c = '{x: c_x, y: c_y, z: c_z};
    assign in_pts.d = '{x: d_x, y: d_y, z: d_z};

    cbs_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pts    (in_pts),
        .seg       (front_seg),
        .seg_valid (front_valid),
        .seg_ready (queue_ready)
    );

    cbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  (front_seg),
        .push_ready (queue_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    cbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .adv        (adv),
        .req        (req)
    );

    cbs_eval #(
        .SAMPLES (SAMPLES)
    ) u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .adv           (adv),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .sample_number (sample_number),
        .last_point    (last_point)
    );

endmodule

@@ design/cbs_front.sv @@
// input stage: takes segments, holds the include_end register, sets run length
module cbs_front #(
    parameter int SAMPLES = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  cbs_pkg::ctrl_pts_t in_pts,
    output cbs_pkg::seg_t      seg,
    output logic               seg_valid,
    input  logic               seg_ready
);
    import cbs_pkg::*;

    logic include_end_reg;
    logic seg_valid_reg;
    logic seg_valid_next;
    seg_t seg_reg;
    logic take;

    assign in_ready = !seg_valid_reg || seg_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        seg_valid_next = seg_valid_reg;
        if (take)
        begin
            seg_valid_next = 1'b1;
        end
        else if (seg_ready)
        begin
            seg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            include_end_reg <= 1'b0;
            seg_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                include_end_reg <= cfg_data;
            end
            seg_valid_reg <= seg_valid_next;
        end
    end

    // run ends at SAMPLES-1, or at SAMPLES when the endpoint is appended
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seg_reg.pts    <= in_pts;
            seg_reg.last_k <= IDX_W'(SAMPLES - 1) + IDX_W'(include_end_reg);
        end
    end

    assign seg       = seg_reg;
    assign seg_valid = seg_valid_reg;

endmodule

@@ design/cbs_queue.sv @@
// two-entry segment queue between the input stage and the sequencer
module cbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbs_pkg::seg_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output cbs_pkg::seg_t head,
    output logic          head_valid
);
    import cbs_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    seg_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/cbs_back.sv @@
// sequencer: walks the sample index of the head segment, one sample per cycle while adv is high
module cbs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbs_pkg::seg_t        head,
    input  logic                 head_valid,
    output logic                 pop,
    input  logic                 adv,
    output cbs_pkg::sample_req_t req
);
    import cbs_pkg::*;

    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic             issue;
    logic             at_last;

    assign issue   = head_valid && adv;
    assign at_last = k_reg == head.last_k;
    assign pop     = issue && at_last;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = at_last ? '0 : k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    assign req.valid = issue;
    assign req.pts   = head.pts;
    assign req.k     = k_reg;
    assign req.last  = at_last;

endmodule

@@ design/cbs_eval.sv @@
// evaluation pipeline: bernstein weights, weighted sums, rounding divide by SAMPLES cubed
module cbs_eval #(
    parameter int SAMPLES = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cbs_pkg::sample_req_t          req,
    output logic                          adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cbs_pkg::coord_t               point_x,
    output cbs_pkg::coord_t               point_y,
    output cbs_pkg::coord_t               point_z,
    output logic [cbs_pkg::IDX_W-1:0]     sample_number,
    output logic                          last_point
);
    import cbs_pkg::*;

    localparam int DEN   = SAMPLES * SAMPLES * SAMPLES;
    localparam int WW    = $clog2(DEN + 1);
    localparam int PW    = WW + COORD_W + 1;
    localparam int SW    = PW + 3;
    localparam int NW    = WW + COORD_W + 1;
    localparam int SQ_W  = 2 * IDX_W;
    localparam int CU_W  = 3 * IDX_W;
    // reciprocal of 2*den scaled by 2^RK, exact for every dividend below 2^NW
    localparam int RK    = NW + WW + 1;
    localparam int MW    = NW + 2;
    localparam int ML    = MW / 2;
    localparam int MH    = MW - ML;
    localparam int LW    = NW + ML;
    localparam int HW    = NW + MH;
    localparam longint RECIP = ((longint'(1) << RK) + longint'(2 * DEN) - 1)
                             / longint'(2 * DEN);
    localparam logic [ML-1:0] RECIP_LO = ML'(RECIP);
    localparam logic [MH-1:0] RECIP_HI = MH'(RECIP >> ML);
    // 2*num + den rounds to nearest; the extra 2*den*2^15 keeps the dividend positive
    localparam logic [SW-1:0] BIAS = SW'((longint'(DEN) << QUOT_W) + longint'(DEN));

    // stage a: squares
    logic             a_valid_reg;
    logic [IDX_W-1:0] a_k_reg;
    logic [IDX_W-1:0] a_u_reg;
    logic [SQ_W-1:0]  a_k2_reg;
    logic [SQ_W-1:0]  a_u2_reg;
    ctrl_pts_t        a_pts_reg;
    logic             a_last_reg;
    logic [IDX_W-1:0] u_next;

    // stage b: weights
    logic             b_valid_reg;
    logic [IDX_W-1:0] b_k_reg;
    logic             b_last_reg;
    ctrl_pts_t        b_pts_reg;
    logic [WW-1:0]    b_w_reg [NUM_CTRL];
    logic [WW-1:0]    b_w_next [NUM_CTRL];
    logic [CU_W-1:0]  u3;
    logic [CU_W-1:0]  k3;
    logic [CU_W-1:0]  ku2;
    logic [CU_W-1:0]  k2u;
    coord_t           b_c [NUM_CTRL][NUM_AXES];

    // stage c: products
    logic                 c_valid_reg;
    logic [IDX_W-1:0]     c_k_reg;
    logic                 c_last_reg;
    logic signed [PW-1:0] c_prod_reg [NUM_CTRL][NUM_AXES];
    logic signed [PW-1:0] c_prod_next [NUM_CTRL][NUM_AXES];

    // stage d: biased dividend
    logic                 d_valid_reg;
    logic [IDX_W-1:0]     d_k_reg;
    logic                 d_last_reg;
    logic [NW-1:0]        d_num_reg [NUM_AXES];
    logic signed [SW-1:0] sum_s [NUM_AXES];
    logic [NW-1:0]        dividend [NUM_AXES];

    // stage e: dividend times the two halves of the reciprocal
    logic                 e_valid_reg;
    logic [IDX_W-1:0]     e_k_reg;
    logic                 e_last_reg;
    logic [LW-1:0]        e_lo_reg [NUM_AXES];
    logic [HW-1:0]        e_hi_reg [NUM_AXES];

    // stage f: quotient
    logic                 f_valid_reg;
    logic [IDX_W-1:0]     f_k_reg;
    logic                 f_last_reg;
    logic [QUOT_W-1:0]    f_quo_reg [NUM_AXES];

    assign adv = !f_valid_reg || out_ready;

    assign u_next = IDX_W'(SAMPLES) - req.k;

    assign u3  = CU_W'(a_u2_reg) * CU_W'(a_u_reg);
    assign k3  = CU_W'(a_k2_reg) * CU_W'(a_k_reg);
    assign ku2 = CU_W'(a_u2_reg) * CU_W'(a_k_reg);
    assign k2u = CU_W'(a_k2_reg) * CU_W'(a_u_reg);

    always_comb
    begin
        b_w_next[0] = WW'(u3);
        b_w_next[1] = WW'((CU_W+2)'(ku2) * (CU_W+2)'(3));
        b_w_next[2] = WW'((CU_W+2)'(k2u) * (CU_W+2)'(3));
        b_w_next[3] = WW'(k3);
    end

    assign b_c[0][0] = b_pts_reg.a.x;
    assign b_c[0][1] = b_pts_reg.a.y;
    assign b_c[0][2] = b_pts_reg.a.z;
    assign b_c[1][0] = b_pts_reg.b.x;
    assign b_c[1][1] = b_pts_reg.b.y;
    assign b_c[1][2] = b_pts_reg.b.z;
    assign b_c[2][0] = b_pts_reg.c.x;
    assign b_c[2][1] = b_pts_reg.c.y;
    assign b_c[2][2] = b_pts_reg.c.z;
    assign b_c[3][0] = b_pts_reg.d.x;
    assign b_c[3][1] = b_pts_reg.d.y;
    assign b_c[3][2] = b_pts_reg.d.z;

    always_comb
    begin
        for (int i = 0; i < NUM_CTRL; i++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                c_prod_next[i][j] = PW'(signed'({1'b0, b_w_reg[i]})) * PW'(b_c[i][j]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            sum_s[j] = SW'(c_prod_reg[0][j]) + SW'(c_prod_reg[1][j])
                     + SW'(c_prod_reg[2][j]) + SW'(c_prod_reg[3][j]);
            dividend[j] = NW'(sum_s[j] + sum_s[j] + BIAS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_k_reg    <= req.k;
            a_u_reg    <= u_next;
            a_k2_reg   <= SQ_W'(req.k) * SQ_W'(req.k);
            a_u2_reg   <= SQ_W'(u_next) * SQ_W'(u_next);
            a_pts_reg  <= req.pts;
            a_last_reg <= req.last;

            b_k_reg    <= a_k_reg;
            b_last_reg <= a_last_reg;
            b_pts_reg  <= a_pts_reg;
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                b_w_reg[i] <= b_w_next[i];
            end

            c_k_reg    <= b_k_reg;
            c_last_reg <= b_last_reg;
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    c_prod_reg[i][j] <= c_prod_next[i][j];
                end
            end

            d_k_reg    <= c_k_reg;
            d_last_reg <= c_last_reg;
            e_k_reg    <= d_k_reg;
            e_last_reg <= d_last_reg;
            f_k_reg    <= e_k_reg;
            f_last_reg <= e_last_reg;
            for (int j = 0; j < NUM_AXES; j++)
            begin
                d_num_reg[j] <= dividend[j];
                e_lo_reg[j]  <= LW'(d_num_reg[j]) * LW'(RECIP_LO);
                e_hi_reg[j]  <= HW'(d_num_reg[j]) * HW'(RECIP_HI);
                f_quo_reg[j] <= QUOT_W'(({e_hi_reg[j], {ML{1'b0}}}
                                         + (NW+MW)'(e_lo_reg[j])) >> RK);
            end
        end
    end

    // quotient is offset by 2^15; flipping the top bit gives two's complement
    assign point_x       = {~f_quo_reg[0][QUOT_W-1], f_quo_reg[0][QUOT_W-2:0]};
    assign point_y       = {~f_quo_reg[1][QUOT_W-1], f_quo_reg[1][QUOT_W-2:0]};
    assign point_z       = {~f_quo_reg[2][QUOT_W-1], f_quo_reg[2][QUOT_W-2:0]};
    assign sample_number = f_k_reg;
    assign last_point    = f_last_reg;
    assign out_valid     = f_valid_reg;

endmodule

@@ dv/tb.sv @@
// testbench for cubic_bezier_sampler_top: stimulus, handshake drivers and point checker
`timescale 1ns / 100ps

module tb;
    import cbs_pkg::*;

    localparam int SAMPLES      = 20;
    localparam int SETTLE_TICKS = 40;
    localparam int HOLD_TICKS   = 300;
    localparam int HOLD_AT      = 60;
    localparam int RANDOM_PHASE = 100;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        coord_t           x;
        coord_t           y;
        coord_t           z;
        logic [IDX_W-1:0] k;
        logic             last;
    } curve_point_t;

    // exact blend of one axis over SAMPLES^3, rounded half up
    function automatic coord_t bezier_coord(coord_t pa, coord_t pb, coord_t pc, coord_t pd,
                                            int k);
        longint s;
        longint u;
        longint den;
        longint num;
        longint q;
        s   = SAMPLES;
        u   = s - k;
        den = s * s * s;
        num = u * u * u * longint'(pa) + 3 * k * u * u * longint'(pb)
            + 3 * k * k * u * longint'(pc) + longint'(k) * k * k * longint'(pd);
        num = 2 * num + den;
        q   = num / (2 * den);
        if ((num % (2 * den)) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return coord_t'(q);
    endfunction

    class point_scoreboard;
        curve_point_t expected_points[$];
        int           mismatch_count;
        int           points_checked;

        function void note_segment(ctrl_pts_t p, bit with_end);
            int total;
            curve_point_t e;
            total = SAMPLES + (with_end ? 1 : 0);
            for (int k = 0; k < total; k++)
            begin
                e.x    = bezier_coord(p.a.x, p.b.x, p.c.x, p.d.x, k);
                e.y    = bezier_coord(p.a.y, p.b.y, p.c.y, p.d.y, k);
                e.z    = bezier_coord(p.a.z, p.b.z, p.c.z, p.d.z, k);
                e.k    = IDX_W'(k);
                e.last = (k == total - 1);
                expected_points.push_back(e);
            end
        endfunction

        function void check_point(curve_point_t got);
            curve_point_t e;
            points_checked++;
            if (expected_points.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected point: x=%0d y=%0d z=%0d k=%0d last=%0b",
                             got.x, got.y, got.z, got.k, got.last);
                return;
            end
            e = expected_points.pop_front();
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.k !== e.k
                || got.last !== e.last)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("point mismatch: expected x=%0d y=%0d z=%0d k=%0d last=%0b, got x=%0d y=%0d z=%0d k=%0d last=%0b",
                             e.x, e.y, e.z, e.k, e.last, got.x, got.y, got.z, got.k, got.last);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write = 1'b0;
    logic             cfg_data = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    ctrl_pts_t        seg_bus = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
    logic [IDX_W-1:0] sample_number;
    logic             last_point;

    point_scoreboard sb = new();
    bit  include_end_now = 1'b0;
    bit  idle_on = 1'b0;
    bit  hold_done = 1'b0;
    bit  seen_end_0 = 1'b0;
    bit  seen_end_1 = 1'b0;
    int  segments_in = 0;
    int  cycle_count = 0;

    cubic_bezier_sampler_top #(.SAMPLES(SAMPLES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .a_x           (seg_bus.a.x),
        .a_y           (seg_bus.a.y),
        .a_z           (seg_bus.a.z),
        .b_x           (seg_bus.b.x),
        .b_y           (seg_bus.b.y),
        .b_z           (seg_bus.b.z),
        .c_x           (seg_bus.c.x),
        .c_y           (seg_bus.c.y),
        .c_z           (seg_bus.c.z),
        .d_x           (seg_bus.d.x),
        .d_y           (seg_bus.d.y),
        .d_z           (seg_bus.d.z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .sample_number (sample_number),
        .last_point    (last_point)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, sb.pending());
            $display("[cubic_bezier_sampler_top] ERROR");
            $finish;
        end
    end

    // transfer monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_segment(seg_bus, include_end_now);
            segments_in++;
            if (include_end_now)
                seen_end_1 = 1'b1;
            else
                seen_end_0 = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_point({point_x, point_y, point_z, sample_number, last_point});
    end

    // receiver: random stall bursts plus one long hold that backs up the block
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && segments_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_TICKS) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic vec3_t v3(int x, int y, int z);
        return {coord_t'(x), coord_t'(y), coord_t'(z)};
    endfunction

    function automatic ctrl_pts_t random_segment();
        ctrl_pts_t p;
        int        mode;
        int        base;
        int        pick;
        mode = $urandom_range(0, 9);
        base = $urandom;
        for (int i = 0; i < NUM_CTRL * NUM_AXES; i++)
        begin
            if (mode <= 4)
                p[i*COORD_W +: COORD_W] = coord_t'($urandom);
            else if (mode <= 6)
                p[i*COORD_W +: COORD_W] = coord_t'(int'($urandom_range(0, 64)) - 32);
            else if (mode == 7)
            begin
                pick = $urandom_range(0, 4);
                p[i*COORD_W +: COORD_W] = (pick == 0) ? coord_t'(32767) :
                                          (pick == 1) ? coord_t'(-32768) :
                                          coord_t'(pick - 3);
            end
            else if (mode == 8)
                p[i*COORD_W +: COORD_W] = coord_t'(base + int'($urandom_range(0, 255)) - 128);
            else
                p[i*COORD_W +: COORD_W] = coord_t'(base);
        end
        return p;
    endfunction

    // offer one segment and hold it until the transfer
    task automatic send_segment(ctrl_pts_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        seg_bus  <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // include_end may only change once every point has come out
    task automatic write_include_end(bit v);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        include_end_now = v;
    endtask

    initial
    begin
        ctrl_pts_t directed[$];
        bit        phase_end[4];
        phase_end = '{1'b0, 1'b1, 1'b1, 1'b0};

        directed.push_back('0);
        directed.push_back({4{v3(32767, 32767, 32767)}});
        directed.push_back({4{v3(-32768, -32768, -32768)}});
        directed.push_back({v3(-32768, 32767, -32768), v3(-32768, 32767, -32768),
                            v3(32767, -32768, 32767), v3(32767, -32768, 32767)});
        directed.push_back({v3(32767, -32768, 0), v3(0, 0, 0),
                            v3(0, 0, 0), v3(-32768, 32767, 0)});
        directed.push_back({v3(32767, -32768, 32767), v3(-32768, 32767, -32768),
                            v3(32767, -32768, 32767), v3(-32768, 32767, -32768)});
        // exact halves at the midpoint, both signs
        directed.push_back({v3(4, -4, 0), v3(0, 0, 4), v3(0, 0, -4), v3(0, 0, 0)});
        directed.push_back({v3(1, -1, 2), v3(0, 0, -2), v3(0, 0, 1), v3(-1, 1, 0)});
        directed.push_back({v3(16'h5555, 16'haaaa, 16'h5555), v3(16'haaaa, 16'h5555, 16'haaaa),
                            v3(16'h5555, 16'haaaa, 16'h5555), v3(16'haaaa, 16'h5555, 16'haaaa)});
        directed.push_back({v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0), v3(1, -1, 32767)});
        directed.push_back({v3(-1, 1, 8), v3(-1, 1, 8), v3(-1, 1, -8), v3(-1, 1, -8)});
        directed.push_back({v3(-1600, 320, 5000), v3(2400, -7000, 12),
                            v3(-30000, 1, 16), v3(100, 27000, -3)});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_include_end(1'b1);
        foreach (directed[i])
            send_segment(directed[i]);
        in_valid <= 1'b0;
        write_include_end(1'b0);
        foreach (directed[i])
            send_segment(directed[i]);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            write_include_end(phase_end[ph]);
            for (int n = 0; n < RANDOM_PHASE; n++)
            begin
                // the closing phase runs flat out on both sides
                if (n % 25 == 0)
                    idle_on = (ph < 3) && ($urandom_range(0, 3) != 0);
                send_segment(random_segment());
            end
            in_valid <= 1'b0;
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("covered %0d segments and %0d curve points, endpoint off %0b on %0b",
                 segments_in, sb.points_checked, seen_end_0, seen_end_1);
        $display("output held for %0d cycles once, %0d mismatches",
                 HOLD_TICKS, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("[cubic_bezier_sampler_top] OK");
        else
            $display("[cubic_bezier_sampler_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
design/cbs_pkg.sv
design/cbs_front.sv
design/cbs_queue.sv
design/cbs_back.sv
design/cbs_eval.sv
design/cubic_bezier_sampler_top.sv
dv/tb.sv
